// ===== rtl/core/rmse_pkg.sv =====
// Shared types, codes and decode helpers for the register machine step engine.
`timescale 1ns / 1ps

package rmse_pkg;

    // Register file geometry
    localparam int NUM_REGS = 6;
    localparam int REG_AW   = 3;

    // Configuration register indexes
    localparam logic [1:0] CFG_PC_SEL   = 2'd0;
    localparam logic [1:0] CFG_PROG_LEN = 2'd1;
    localparam logic [1:0] CFG_INIT_R0  = 2'd2;

    // Request kinds
    typedef enum logic [1:0] {
        REQ_LOAD    = 2'd0,
        REQ_STEP    = 2'd1,
        REQ_RESTART = 2'd2
    } t_req;

    // Result status codes
    typedef enum logic [2:0] {
        ST_LOADED    = 3'd0,
        ST_EXECUTED  = 3'd1,
        ST_HALTED    = 3'd2,
        ST_BAD       = 3'd3,
        ST_RESTARTED = 3'd4
    } t_status;

    // Opcodes
    typedef enum logic [3:0] {
        OP_ADDR = 4'd0,
        OP_ADDI = 4'd1,
        OP_MULR = 4'd2,
        OP_MULI = 4'd3,
        OP_BANR = 4'd4,
        OP_BANI = 4'd5,
        OP_BORR = 4'd6,
        OP_BORI = 4'd7,
        OP_SETR = 4'd8,
        OP_SETI = 4'd9,
        OP_GTIR = 4'd10,
        OP_GTRI = 4'd11,
        OP_GTRR = 4'd12,
        OP_EQIR = 4'd13,
        OP_EQRI = 4'd14,
        OP_EQRR = 4'd15
    } t_op;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_SYNC,
        S_OPS,
        S_EXEC,
        S_MUL,
        S_PCWR,
        S_REPLY
    } t_state;

    // One program word as held in the store
    typedef struct packed {
        logic [3:0]  op;
        logic [31:0] a;
        logic [31:0] b;
        logic [2:0]  c;
    } t_instr;

    localparam int INSTR_W = $bits(t_instr);

    // One buffered input item
    typedef struct packed {
        logic [1:0]         req_type;
        logic [5:0]         load_index;
        logic [3:0]         opcode;
        logic signed [31:0] operand_a;
        logic signed [31:0] operand_b;
        logic [2:0]         operand_c;
    } t_item;

    // Sequencer to ALU control
    typedef struct packed {
        logic start;
        t_op  op;
    } t_alu_ctl;

    // bit 0: operand a names a register, bit 1: operand b names a register
    function automatic logic [1:0] reg_use(input logic [3:0] op);
        logic [1:0] u;
        case (op)
            OP_ADDR, OP_MULR, OP_BANR, OP_BORR, OP_GTRR, OP_EQRR: u = 2'b11;
            OP_ADDI, OP_MULI, OP_BANI, OP_BORI, OP_SETR, OP_GTRI, OP_EQRI: u = 2'b01;
            OP_GTIR, OP_EQIR: u = 2'b10;
            default: u = 2'b00;
        endcase
        return u;
    endfunction

    // A 32-bit operand that is a legal register index
    function automatic logic reg_ok(input logic [31:0] v);
        return (v[31:3] == 29'd0) && (v[2:0] < 3'(NUM_REGS));
    endfunction

endpackage

// ===== rtl/core/rmse_if.sv =====
// Channel interfaces: request, response and configuration write.
`timescale 1ns / 1ps

interface rmse_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         req_type;
    logic [5:0]         load_index;
    logic [3:0]         opcode;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
    logic [2:0]         operand_c;

    modport source (output valid, req_type, load_index, opcode, operand_a, operand_b,
                    operand_c, input ready);
    modport sink (input valid, req_type, load_index, opcode, operand_a, operand_b,
                  operand_c, output ready);
endinterface

interface rmse_rsp_if;
    logic               valid;
    logic               ready;
    logic [2:0]         status;
    logic signed [31:0] first_register;
    logic signed [31:0] program_counter;

    modport source (output valid, status, first_register, program_counter, input ready);
    modport sink (input valid, status, first_register, program_counter, output ready);
endinterface

interface rmse_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  idx;
    logic [31:0] data;

    modport source (output valid, idx, data, input ready);
    modport sink (input valid, idx, data, output ready);
endinterface

// ===== rtl/core/rmse_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module rmse_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/rmse_alu.sv =====
// Execute unit: combinational add, logic, set and compare ops and a sequenced wrapping multiplier.
`timescale 1ns / 1ps

module rmse_alu #(
    parameter int WORD_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  rmse_pkg::t_alu_ctl    i_ctl,
    input  logic [WORD_WIDTH-1:0] i_ra,
    input  logic [WORD_WIDTH-1:0] i_rb,
    input  logic signed [31:0]    i_opa,
    input  logic signed [31:0]    i_opb,
    output logic [WORD_WIDTH-1:0] o_res,
    output logic                  o_mul_done,
    output logic [WORD_WIDTH-1:0] o_mul_res
);

    // 32x32 partial products: low*low, then the two cross terms for wide words
    localparam int MUL_STEPS = (WORD_WIDTH > 32) ? 3 : 1;

    logic [WORD_WIDTH-1:0] ia;
    logic [WORD_WIDTH-1:0] ib;
    logic [63:0] r_x;
    logic [63:0] r_y;
    logic [63:0] r_prod;
    logic [63:0] r_acc;
    logic [1:0]  r_cnt;
    logic        r_busy;
    logic        r_pv;
    logic        r_psh;
    logic        r_last;
    logic        r_done;
    logic [31:0] mx;
    logic [31:0] my;

    // Immediates: sign-extend from 32 bits, wrap to the word
    assign ia = WORD_WIDTH'(i_opa);
    assign ib = WORD_WIDTH'(i_opb);

    // Combinational operations
    always_comb begin
        case (i_ctl.op)
            rmse_pkg::OP_ADDR: o_res = i_ra + i_rb;
            rmse_pkg::OP_ADDI: o_res = i_ra + ib;
            rmse_pkg::OP_BANR: o_res = i_ra & i_rb;
            rmse_pkg::OP_BANI: o_res = i_ra & ib;
            rmse_pkg::OP_BORR: o_res = i_ra | i_rb;
            rmse_pkg::OP_BORI: o_res = i_ra | ib;
            rmse_pkg::OP_SETR: o_res = i_ra;
            rmse_pkg::OP_SETI: o_res = ia;
            rmse_pkg::OP_GTIR: o_res = WORD_WIDTH'($signed(ia) > $signed(i_rb));
            rmse_pkg::OP_GTRI: o_res = WORD_WIDTH'($signed(i_ra) > $signed(ib));
            rmse_pkg::OP_GTRR: o_res = WORD_WIDTH'($signed(i_ra) > $signed(i_rb));
            rmse_pkg::OP_EQIR: o_res = WORD_WIDTH'(ia == i_rb);
            rmse_pkg::OP_EQRI: o_res = WORD_WIDTH'(i_ra == ib);
            rmse_pkg::OP_EQRR: o_res = WORD_WIDTH'(i_ra == i_rb);
            default:           o_res = '0;
        endcase
    end

    // Operand halves for the current partial product
    always_comb begin
        case (r_cnt)
            2'd0:    begin mx = r_x[31:0];  my = r_y[31:0];  end
            2'd1:    begin mx = r_x[63:32]; my = r_y[31:0];  end
            default: begin mx = r_x[31:0];  my = r_y[63:32]; end
        endcase
    end

    // Multiply sequencer control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pv   <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_pv   <= 1'b0;
            end else if (r_busy) begin
                r_pv <= (r_cnt != 2'(MUL_STEPS));
                if (r_cnt != 2'(MUL_STEPS)) begin
                    r_cnt <= r_cnt + 2'd1;
                end
                if (r_pv && r_last) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    r_pv   <= 1'b0;
                end
            end else begin
                r_pv <= 1'b0;
            end
        end
    end

    // Multiply datapath: product register, then shifted accumulate
    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_x   <= 64'(i_ra);
            r_y   <= (i_ctl.op == rmse_pkg::OP_MULI) ? 64'(ib) : 64'(i_rb);
            r_acc <= '0;
        end else begin
            if (r_busy && (r_cnt != 2'(MUL_STEPS))) begin
                r_prod <= mx * my;
                r_psh  <= (r_cnt != 2'd0);
                r_last <= (r_cnt == 2'(MUL_STEPS - 1));
            end
            if (r_pv) begin
                r_acc <= r_acc + (r_psh ? (r_prod << 32) : r_prod);
            end
        end
    end

    assign o_mul_done = r_done;
    assign o_mul_res  = WORD_WIDTH'(r_acc);

endmodule

// ===== rtl/core/register_machine_step_engine_top.sv =====
// Top level: input buffer, step sequencer, program store, register file and reply register.
//
// Channel  Dir  Handshake      Payload
// i_req    in   valid/ready    req_type, load_index, opcode, operand_a, operand_b, operand_c
// o_rsp    out  valid/ready    status, first_register, program_counter
// i_cfg    in   valid/ready    idx (register index), data
//
// Load, restart, halted, unknown and bad-selection items go from idle straight to the reply
// state; a bad operand in the fetched word is caught in the operand read state. A step runs
// the fetch, operand read, write and counter write-back through the register file RAM (no
// counter write-back when the destination is the counter register); a multiply adds the
// multiply state. A change to a valid counter selection costs one shadow reload before the next item.
// Reset (synchronous, i_rst_n low) clears control and the register valid bits and resets config.
// The input buffer takes the next item while one is in work; a stalled reply holds the
// sequencer in its reply state.
`timescale 1ns / 1ps

module register_machine_step_engine_top #(
    parameter int PROGRAM_DEPTH = 64,
    parameter int WORD_WIDTH    = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rmse_req_if.sink   i_req,
    rmse_rsp_if.source o_rsp,
    rmse_cfg_if.sink   i_cfg
);

    localparam int W    = WORD_WIDTH;
    localparam int PAW  = (PROGRAM_DEPTH > 1) ? $clog2(PROGRAM_DEPTH) : 1;
    localparam int LENW = 11;

    // Config registers
    logic [2:0]         r_sel;
    logic [6:0]         r_len;
    logic signed [31:0] r_init;
    logic               r_resync;
    logic               n_resync;
    logic               cfg_wr;

    // Input buffer
    logic                r_in_full;
    rmse_pkg::t_item     r_in;
    logic                in_acc;
    logic                pull;

    // Sequencer
    rmse_pkg::t_state    r_state;
    rmse_pkg::t_state    n_state;
    rmse_pkg::t_status   r_status;
    rmse_pkg::t_status   n_status;

    // Register shadows and valid bits
    logic [rmse_pkg::NUM_REGS-1:0] r_rvalid;
    logic [W-1:0]        r_init0;
    logic [W-1:0]        r_r0;
    logic [W-1:0]        r_pc;
    logic [W-1:0]        init_w;
    logic                restart;

    // Reply register
    logic                r_out_valid;
    rmse_pkg::t_status   r_out_status;
    logic [31:0]         r_out_r0;
    logic [31:0]         r_out_pc;
    logic                out_free;
    logic                out_load;

    // Program store
    logic                prog_we;
    logic                prog_re;
    logic [PAW-1:0]      prog_waddr;
    logic [PAW-1:0]      prog_raddr;
    rmse_pkg::t_instr    prog_wdata;
    logic [rmse_pkg::INSTR_W-1:0] prog_rdata;
    rmse_pkg::t_instr    instr;

    // Register file (two copies for two read ports)
    logic                rf_we;
    logic [rmse_pkg::REG_AW-1:0] rf_waddr;
    logic [W-1:0]        rf_wdata;
    logic                rf_re;
    logic [rmse_pkg::REG_AW-1:0] rf_raddr0;
    logic [rmse_pkg::REG_AW-1:0] rf_raddr1;
    logic [rmse_pkg::REG_AW-1:0] r_rd_addr0;
    logic [rmse_pkg::REG_AW-1:0] r_rd_addr1;
    logic [W-1:0]        rf_rdata0;
    logic [W-1:0]        rf_rdata1;
    logic [W-1:0]        ra;
    logic [W-1:0]        rb;

    // Decode
    logic                sel_ok;
    logic [LENW-1:0]     len_c;
    logic                pc_in_range;
    logic                load_ok;
    logic [1:0]          use_ab;
    logic                ops_ok;
    logic                is_mul;
    logic                dest_is_pc;
    logic                wb_fire;
    logic [W-1:0]        wb_res;
    logic [W-1:0]        wb_val;

    // ALU
    rmse_pkg::t_alu_ctl  alu_ctl;
    logic [W-1:0]        alu_res;
    logic                alu_done;
    logic [W-1:0]        alu_mul_res;

    // A register entry not written since restart reads as its restart value
    function automatic logic [W-1:0] rf_value(input logic [rmse_pkg::REG_AW-1:0] addr,
                                               input logic [W-1:0] data);
        logic [W-1:0] v;
        if (r_rvalid[addr]) begin
            v = data;
        end else if (addr == '0) begin
            v = r_init0;
        end else begin
            v = '0;
        end
        return v;
    endfunction

    // Handshakes
    assign i_cfg.ready = 1'b1;
    assign cfg_wr      = i_cfg.valid & i_cfg.ready;
    assign i_req.ready = !r_in_full || pull;
    assign in_acc      = i_req.valid & i_req.ready;
    assign out_free    = !r_out_valid || o_rsp.ready;

    assign o_rsp.valid           = r_out_valid;
    assign o_rsp.status          = r_out_status;
    assign o_rsp.first_register  = r_out_r0;
    assign o_rsp.program_counter = r_out_pc;

    // Decode of config, buffered item and fetched word
    assign init_w      = W'(r_init);
    assign sel_ok      = r_sel < 3'(rmse_pkg::NUM_REGS);
    assign len_c       = (LENW'(r_len) > LENW'(PROGRAM_DEPTH)) ? LENW'(PROGRAM_DEPTH)
                                                             : LENW'(r_len);
    assign pc_in_range = !r_pc[W-1] && (r_pc < W'(len_c));
    assign load_ok     = LENW'(r_in.load_index) < LENW'(PROGRAM_DEPTH);
    assign instr       = rmse_pkg::t_instr'(prog_rdata);
    assign use_ab      = rmse_pkg::reg_use(instr.op);
    assign ops_ok      = (instr.c < 3'(rmse_pkg::NUM_REGS))
                       && (!use_ab[0] || rmse_pkg::reg_ok(instr.a))
                       && (!use_ab[1] || rmse_pkg::reg_ok(instr.b));
    assign is_mul      = (instr.op == rmse_pkg::OP_MULR) || (instr.op == rmse_pkg::OP_MULI);
    assign dest_is_pc  = (instr.c == r_sel);
    assign ra          = rf_value(r_rd_addr0, rf_rdata0);
    assign rb          = rf_value(r_rd_addr1, rf_rdata1);
    assign wb_res      = (r_state == rmse_pkg::S_MUL) ? alu_mul_res : alu_res;
    assign wb_val      = dest_is_pc ? (wb_res + W'(1)) : wb_res;

    assign prog_waddr = PAW'(r_in.load_index);
    assign prog_raddr = PAW'(r_pc);
    assign prog_wdata = '{op: r_in.opcode, a: r_in.operand_a, b: r_in.operand_b,
                          c: r_in.operand_c};

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            rmse_pkg::S_IDLE: begin
                if (r_resync) begin
                    n_state = sel_ok ? rmse_pkg::S_SYNC : rmse_pkg::S_IDLE;
                end else if (r_in_full) begin
                    if ((r_in.req_type == rmse_pkg::REQ_STEP) && sel_ok && pc_in_range) begin
                        n_state = rmse_pkg::S_OPS;
                    end else begin
                        n_state = rmse_pkg::S_REPLY;
                    end
                end
            end
            rmse_pkg::S_SYNC: n_state = rmse_pkg::S_IDLE;
            rmse_pkg::S_OPS:  n_state = ops_ok ? rmse_pkg::S_EXEC : rmse_pkg::S_REPLY;
            rmse_pkg::S_EXEC: begin
                if (is_mul) begin
                    n_state = rmse_pkg::S_MUL;
                end else begin
                    n_state = dest_is_pc ? rmse_pkg::S_REPLY : rmse_pkg::S_PCWR;
                end
            end
            rmse_pkg::S_MUL: begin
                if (alu_done) begin
                    n_state = dest_is_pc ? rmse_pkg::S_REPLY : rmse_pkg::S_PCWR;
                end
            end
            rmse_pkg::S_PCWR:  n_state = rmse_pkg::S_REPLY;
            rmse_pkg::S_REPLY: n_state = out_free ? rmse_pkg::S_IDLE : rmse_pkg::S_REPLY;
            default:           n_state = rmse_pkg::S_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        pull      = 1'b0;
        prog_we   = 1'b0;
        prog_re   = 1'b0;
        restart   = 1'b0;
        rf_re     = 1'b0;
        rf_raddr0 = r_sel;
        rf_raddr1 = r_sel;
        wb_fire   = 1'b0;
        out_load  = 1'b0;
        alu_ctl   = '{start: 1'b0, op: rmse_pkg::t_op'(instr.op)};
        n_status  = r_status;
        case (r_state)
            rmse_pkg::S_IDLE: begin
                if (r_resync) begin
                    rf_re = sel_ok;
                end else if (r_in_full) begin
                    pull = 1'b1;
                    case (r_in.req_type)
                        rmse_pkg::REQ_LOAD: begin
                            prog_we  = load_ok;
                            n_status = rmse_pkg::ST_LOADED;
                        end
                        rmse_pkg::REQ_STEP: begin
                            if (!sel_ok) begin
                                n_status = rmse_pkg::ST_BAD;
                            end else if (!pc_in_range) begin
                                n_status = rmse_pkg::ST_HALTED;
                            end else begin
                                prog_re = 1'b1;
                            end
                        end
                        rmse_pkg::REQ_RESTART: begin
                            restart  = 1'b1;
                            n_status = rmse_pkg::ST_RESTARTED;
                        end
                        default: n_status = rmse_pkg::ST_BAD;
                    endcase
                end
            end
            rmse_pkg::S_OPS: begin
                if (ops_ok) begin
                    rf_re     = 1'b1;
                    rf_raddr0 = instr.a[rmse_pkg::REG_AW-1:0];
                    rf_raddr1 = instr.b[rmse_pkg::REG_AW-1:0];
                end else begin
                    n_status = rmse_pkg::ST_BAD;
                end
            end
            rmse_pkg::S_EXEC: begin
                if (is_mul) begin
                    alu_ctl.start = 1'b1;
                end else begin
                    wb_fire = 1'b1;
                end
            end
            rmse_pkg::S_MUL: wb_fire = alu_done;
            rmse_pkg::S_REPLY: out_load = out_free;
            default: ;
        endcase
        if (wb_fire) begin
            n_status = rmse_pkg::ST_EXECUTED;
        end
    end

    // Register file write: destination, or counter increment
    always_comb begin
        rf_we    = 1'b0;
        rf_waddr = instr.c;
        rf_wdata = wb_val;
        if (wb_fire) begin
            rf_we = 1'b1;
        end else if (r_state == rmse_pkg::S_PCWR) begin
            rf_we    = 1'b1;
            rf_waddr = r_sel;
            rf_wdata = r_pc + W'(1);
        end
    end

    assign n_resync = (cfg_wr && (i_cfg.idx == rmse_pkg::CFG_PC_SEL))
                    || (r_resync && (r_state != rmse_pkg::S_IDLE));

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rmse_pkg::S_IDLE;
            r_status    <= rmse_pkg::ST_LOADED;
            r_in_full   <= 1'b0;
            r_out_valid <= 1'b0;
            r_resync    <= 1'b0;
            r_sel       <= '0;
            r_len       <= '0;
            r_init      <= 32'sd1;
        end else begin
            r_state  <= n_state;
            r_status <= n_status;
            r_resync <= n_resync;
            if (in_acc) begin
                r_in_full <= 1'b1;
            end else if (pull) begin
                r_in_full <= 1'b0;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            if (cfg_wr) begin
                case (i_cfg.idx)
                    rmse_pkg::CFG_PC_SEL:   r_sel  <= i_cfg.data[2:0];
                    rmse_pkg::CFG_PROG_LEN: r_len  <= i_cfg.data[6:0];
                    rmse_pkg::CFG_INIT_R0:  r_init <= i_cfg.data;
                    default: ;
                endcase
            end
        end
    end

    // Register shadows and valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rvalid <= '0;
            r_init0  <= W'(1);
            r_r0     <= W'(1);
            r_pc     <= W'(1);
        end else if (restart) begin
            r_rvalid <= '0;
            r_init0  <= init_w;
            r_r0     <= init_w;
            r_pc     <= (r_sel == '0) ? init_w : '0;
        end else if (r_state == rmse_pkg::S_SYNC) begin
            r_pc <= ra;
        end else if (rf_we) begin
            r_rvalid[rf_waddr] <= 1'b1;
            if (rf_waddr == '0) begin
                r_r0 <= rf_wdata;
            end
            if (rf_waddr == r_sel) begin
                r_pc <= rf_wdata;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in <= '{req_type: i_req.req_type, load_index: i_req.load_index,
                      opcode: i_req.opcode, operand_a: i_req.operand_a,
                      operand_b: i_req.operand_b, operand_c: i_req.operand_c};
        end
        if (rf_re) begin
            r_rd_addr0 <= rf_raddr0;
            r_rd_addr1 <= rf_raddr1;
        end
        if (out_load) begin
            r_out_status <= r_status;
            r_out_r0     <= 32'(r_r0);
            r_out_pc     <= sel_ok ? 32'(r_pc) : 32'd0;
        end
    end

    // Program store
    rmse_ram #(
        .WIDTH (rmse_pkg::INSTR_W),
        .DEPTH (PROGRAM_DEPTH)
    ) u_prog (
        .i_clk   (i_clk),
        .i_we    (prog_we),
        .i_waddr (prog_waddr),
        .i_wdata (prog_wdata),
        .i_re    (prog_re),
        .i_raddr (prog_raddr),
        .o_rdata (prog_rdata)
    );

    // Register file, copy for operand a and counter reload
    rmse_ram #(
        .WIDTH (W),
        .DEPTH (rmse_pkg::NUM_REGS)
    ) u_rf_a (
        .i_clk   (i_clk),
        .i_we    (rf_we),
        .i_waddr (rf_waddr),
        .i_wdata (rf_wdata),
        .i_re    (rf_re),
        .i_raddr (rf_raddr0),
        .o_rdata (rf_rdata0)
    );

    // Register file, copy for operand b
    rmse_ram #(
        .WIDTH (W),
        .DEPTH (rmse_pkg::NUM_REGS)
    ) u_rf_b (
        .i_clk   (i_clk),
        .i_we    (rf_we),
        .i_waddr (rf_waddr),
        .i_wdata (rf_wdata),
        .i_re    (rf_re),
        .i_raddr (rf_raddr1),
        .o_rdata (rf_rdata1)
    );

    // Execute unit
    rmse_alu #(
        .WORD_WIDTH (W)
    ) u_alu (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (alu_ctl),
        .i_ra       (ra),
        .i_rb       (rb),
        .i_opa      (instr.a),
        .i_opb      (instr.b),
        .o_res      (alu_res),
        .o_mul_done (alu_done),
        .o_mul_res  (alu_mul_res)
    );

    // Checks
    a_rf_waddr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rf_we |-> (rf_waddr < 3'(rmse_pkg::NUM_REGS)))
        else $error("register file write to a missing register");

    a_reply_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == rmse_pkg::S_REPLY))
        else $error("reply raised outside the reply state");

    a_restart_clr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        restart |=> (r_rvalid == '0))
        else $error("restart left register entries marked written");

    a_pcwr_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rmse_pkg::S_PCWR) |->
            (($past(r_state) == rmse_pkg::S_EXEC) || ($past(r_state) == rmse_pkg::S_MUL)))
        else $error("counter write-back without a destination write");

    a_mul_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        alu_done |-> (r_state == rmse_pkg::S_MUL))
        else $error("multiplier finished outside the multiply state");

endmodule
